@@ hw/rtl/bsmd_pkg.sv @@
// ============================================================================
// bsmd_pkg
// Shared widths, limits and sequencer state type for the mean-distance
// bounding sphere block.
// ============================================================================
package bsmd_pkg;

    localparam int unsigned MaxVerticesDefault = 1024;
    localparam int unsigned CoordW  = 32;
    localparam int unsigned RadiusW = 33;
    localparam int unsigned DiffW   = 33;
    localparam int unsigned SqW     = 66;
    localparam int unsigned DistW   = 34;
    localparam int unsigned DivW    = 64;

    typedef enum logic [7:0] {
        ST_LOAD   = 8'b0000_0001,
        ST_DIV    = 8'b0000_0010,
        ST_FETCH  = 8'b0000_0100,
        ST_SQUARE = 8'b0000_1000,
        ST_SQRT   = 8'b0001_0000,
        ST_ACCUM  = 8'b0010_0000,
        ST_MEAN   = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } bsmd_state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } bsmd_unit_ctl_t;

endpackage

@@ hw/rtl/bsmd_divider.sv @@
// ============================================================================
// bsmd_divider
// Restoring divider, one quotient bit per cycle, signed dividend truncated
// toward zero, unsigned divisor.
// ============================================================================
module bsmd_divider
    import bsmd_pkg::*;
#(
    parameter int unsigned CntW = 11
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic signed [DivW-1:0] dividend,
    input  logic [CntW-1:0]        divisor,
    output logic                   busy,
    output logic signed [DivW-1:0] quotient
);

    localparam int unsigned StepW = $clog2(DivW + 1);

    logic [DivW-1:0]  quo_reg, quo_next;
    logic [DivW:0]    rem_reg, rem_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             neg_reg, neg_next;
    logic [DivW:0]    trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg[DivW-1:0], quo_reg[DivW-1]};
        if (start) begin
            neg_next  = dividend[DivW-1];
            quo_next  = dividend[DivW-1] ? DivW'(-dividend) : DivW'(dividend);
            rem_next  = '0;
            step_next = StepW'(DivW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= (DivW+1)'(divisor)) begin
                rem_next = trial - (DivW+1)'(divisor);
                quo_next = {quo_reg[DivW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[DivW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

@@ hw/rtl/bsmd_sqrt.sv @@
// ============================================================================
// bsmd_sqrt
// Bit-serial floor square root, one result bit per cycle.
// ============================================================================
module bsmd_sqrt
    import bsmd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SqW-1:0]   radicand,
    output logic             busy,
    output logic [DistW-1:0] root
);

    localparam int unsigned StepW = $clog2(DistW + 1);

    logic [SqW-1:0]   val_reg, val_next;
    logic [DistW+1:0] rem_reg, rem_next;
    logic [DistW-1:0] root_reg, root_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             busy_reg, busy_next;
    logic [DistW+1:0] trial, sub;

    always_comb begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        trial = {rem_reg[DistW-1:0], val_reg[SqW-1 -: 2]};
        sub   = {root_reg, 2'b01};
        if (start) begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = StepW'(SqW / 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[SqW-3:0], 2'b00};
            if (trial >= sub) begin
                rem_next  = trial - sub;
                root_next = {root_reg[DistW-2:0], 1'b1};
            end else begin
                rem_next  = trial;
                root_next = {root_reg[DistW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

@@ hw/rtl/bounding_sphere_mean_distance.sv @@
// ============================================================================
// bounding_sphere_mean_distance
// Centroid and mean-distance radius over a run of stored 3D vertices.
// ============================================================================
// Usage:
//   s_axis carries one vertex per transaction (x, y, z in tdata, last in
//   tlast). Vertices load one per cycle while tlast is low: each is written
//   to the vertex memory and added to the per-axis sums.
//   The transaction with tlast high ends the set. The block then drops
//   s_axis_tready and runs its sequencer: three divides for the center,
//   then per stored vertex a memory read, three 33x33 squarings on one
//   shared multiplier, a square root and an accumulate, then a divide
//   for the mean.
//   The result sits in an output register until m_axis_tready; the block
//   takes no new vertex until that transaction completes.
//   Vertices beyond MAX_VERTICES are dropped and flag overflowed.
//   Reset clears count, sums and flag; the memory needs no clearing.
// ============================================================================
module bounding_sphere_mean_distance
    import bsmd_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [135:0]  m_axis_tdata,   // center_x, center_y, center_z, radius, overflowed, pad
    output logic          m_axis_tlast
);

    localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);
    localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned SumW  = CoordW + CntW;
    localparam int unsigned DsumW = DistW + CntW;

    logic [3*CoordW-1:0] mem [MAX_VERTICES];
    logic [3*CoordW-1:0] rd_data_reg;

    bsmd_state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [CntW-1:0] idx_reg, idx_next;
    logic signed [SumW-1:0] sum_reg [3];
    logic signed [SumW-1:0] sum_next [3];
    logic signed [CoordW-1:0] ctr_reg [3];
    logic signed [CoordW-1:0] ctr_next [3];
    logic [DsumW-1:0] dsum_reg, dsum_next;
    logic [RadiusW-1:0] radius_reg, radius_next;
    logic ovf_reg, ovf_next;
    logic [1:0] axis_reg, axis_next;
    logic [SqW-1:0] sq_reg, sq_next;
    logic [2*DiffW-1:0] prod_reg;
    logic prod_vld_reg;
    logic div_start, sqrt_start, div_busy, sqrt_busy;
    logic signed [DivW-1:0] div_dividend, div_q;
    logic [DistW-1:0] root;
    logic s_fire, m_fire, wr_en;
    logic signed [CoordW-1:0] coord;
    logic signed [CoordW-1:0] ctr_sel;
    logic signed [DiffW-1:0] diff;
    logic [DiffW-1:0] adiff;
    bsmd_unit_ctl_t div_ctl;

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign wr_en  = s_fire && (count_reg < CntW'(MAX_VERTICES));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AddrW-1:0]] <= s_axis_tdata;
        end
        rd_data_reg <= mem[idx_reg[AddrW-1:0]];
    end

    always_comb begin
        case (axis_reg)
            2'd0: begin
                coord   = rd_data_reg[31:0];
                ctr_sel = ctr_reg[0];
            end
            2'd1: begin
                coord   = rd_data_reg[63:32];
                ctr_sel = ctr_reg[1];
            end
            default: begin
                coord   = rd_data_reg[95:64];
                ctr_sel = ctr_reg[2];
            end
        endcase
        diff  = DiffW'(coord) - DiffW'(ctr_sel);
        adiff = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= adiff * adiff;
        prod_vld_reg <= (state_reg == ST_SQUARE);
    end

    always_comb begin
        case (axis_reg)
            2'd0:    div_dividend = DivW'(sum_reg[0]);
            2'd1:    div_dividend = DivW'(sum_reg[1]);
            2'd2:    div_dividend = DivW'(sum_reg[2]);
            default: div_dividend = $signed({{(DivW-DsumW){1'b0}}, dsum_reg});
        endcase
    end

    assign div_ctl.start = div_start;
    assign div_ctl.busy  = div_busy;

    bsmd_divider #(.CntW(CntW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dividend), .divisor(count_reg),
        .busy(div_busy), .quotient(div_q)
    );

    bsmd_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .radicand(sq_reg), .busy(sqrt_busy), .root(root)
    );

    logic div_wait_reg, sqrt_wait_reg;
    logic div_wait_next, sqrt_wait_next;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        ctr_next   = ctr_reg;
        dsum_next  = dsum_reg;
        radius_next = radius_reg;
        ovf_next   = ovf_reg;
        axis_next  = axis_reg;
        sq_next    = sq_reg;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        div_wait_next  = div_wait_reg;
        sqrt_wait_next = sqrt_wait_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (wr_en) begin
                        sum_next[0] = sum_reg[0] + SumW'($signed(s_axis_tdata[31:0]));
                        sum_next[1] = sum_reg[1] + SumW'($signed(s_axis_tdata[63:32]));
                        sum_next[2] = sum_reg[2] + SumW'($signed(s_axis_tdata[95:64]));
                        count_next  = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        state_next = ST_DIV;
                        axis_next  = 2'd0;
                        div_wait_next = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                if (!div_wait_reg) begin
                    div_start = 1'b1;
                    div_wait_next = 1'b1;
                end else if (!div_busy && !div_ctl.start) begin
                    ctr_next[axis_reg] = div_q[CoordW-1:0];
                    div_wait_next = 1'b0;
                    if (axis_reg == 2'd2) begin
                        axis_next  = 2'd0;
                        idx_next   = '0;
                        dsum_next  = '0;
                        state_next = ST_FETCH;
                    end else begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                sq_next    = '0;
                axis_next  = 2'd0;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                if (prod_vld_reg) begin
                    sq_next = sq_reg + SqW'(prod_reg);
                end
                if (axis_reg == 2'd3) begin
                    state_next = ST_SQRT;
                    sqrt_wait_next = 1'b0;
                end else begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                if (!sqrt_wait_reg) begin
                    sqrt_start = 1'b1;
                    sqrt_wait_next = 1'b1;
                end else if (!sqrt_busy) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                dsum_next = dsum_reg + DsumW'(root);
                if (idx_reg + 1'b1 == count_reg) begin
                    state_next = ST_MEAN;
                    axis_next  = 2'd3;
                    div_wait_next = 1'b0;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_MEAN: begin
                if (!div_wait_reg) begin
                    div_start = 1'b1;
                    div_wait_next = 1'b1;
                end else if (!div_busy) begin
                    radius_next = div_q[RadiusW-1:0];
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_fire) begin
                    count_next = '0;
                    sum_next[0] = '0;
                    sum_next[1] = '0;
                    sum_next[2] = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
            ovf_reg       <= 1'b0;
            div_wait_reg  <= 1'b0;
            sqrt_wait_reg <= 1'b0;
            axis_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            div_wait_reg  <= div_wait_next;
            sqrt_wait_reg <= sqrt_wait_next;
            axis_reg      <= axis_next;
        end
        idx_reg    <= idx_next;
        ctr_reg    <= ctr_next;
        dsum_reg   <= dsum_next;
        radius_reg <= radius_next;
        sq_reg     <= sq_next;
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tlast  = 1'b1;
    assign m_axis_tdata  = {6'd0, ovf_reg, radius_reg, ctr_reg[2], ctr_reg[1], ctr_reg[0]};

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_axis_tready)
        else $error("vertex accepted while computing");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(MAX_VERTICES))
        else $error("vertex count beyond capacity");
    a_out_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire |=> (count_reg == '0 && !ovf_reg))
        else $error("set not cleared after result");

endmodule

@@ tb/bounding_sphere_mean_distance_checker.sv @@
// ----------------------------------------------------------------------------
// bounding_sphere_mean_distance_checker
// Watches both stream channels, predicts the center, the mean-distance radius
// and the overflow flag for every vertex set, and compares each result
// transaction field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module bounding_sphere_mean_distance_checker
    import bsmd_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = MaxVerticesDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [135:0] m_axis_tdata,
    output int           fail_count,
    output int           pending_spheres
);

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [32:0] radius;
        logic        overflowed;
    } sphere_t;

    logic signed [31:0] set_x [MAX_VERTICES];
    logic signed [31:0] set_y [MAX_VERTICES];
    logic signed [31:0] set_z [MAX_VERTICES];
    int unsigned        set_count;
    logic signed [63:0] sum_x, sum_y, sum_z;
    logic               set_dropped;
    sphere_t            expected_spheres [$];

    function automatic logic [33:0] floor_sqrt(input logic [67:0] n);
        logic [33:0] r;
        logic [33:0] t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (34'd1 << b);
            if ({34'd0, t} * {34'd0, t} <= n) r = t;
        end
        return r;
    endfunction

    function automatic sphere_t predict_sphere();
        sphere_t s;
        logic signed [63:0] c [3];
        logic signed [63:0] d;
        logic [67:0] sq;
        logic [63:0] dist_total;
        c[0] = sum_x / $signed({32'd0, set_count});
        c[1] = sum_y / $signed({32'd0, set_count});
        c[2] = sum_z / $signed({32'd0, set_count});
        dist_total = '0;
        for (int i = 0; i < set_count; i++) begin
            sq = '0;
            d = set_x[i] - c[0];
            if (d < 0) d = -d;
            sq += 68'(d) * 68'(d);
            d = set_y[i] - c[1];
            if (d < 0) d = -d;
            sq += 68'(d) * 68'(d);
            d = set_z[i] - c[2];
            if (d < 0) d = -d;
            sq += 68'(d) * 68'(d);
            dist_total += 64'(floor_sqrt(sq));
        end
        s.cx = c[0][31:0];
        s.cy = c[1][31:0];
        s.cz = c[2][31:0];
        s.radius = 33'(dist_total / 64'(set_count));
        s.overflowed = set_dropped;
        return s;
    endfunction

    assign pending_spheres = expected_spheres.size();

    always @(posedge aclk) begin
        sphere_t got, want;
        if (!aresetn) begin
            set_count <= 0;
            sum_x <= '0;
            sum_y <= '0;
            sum_z <= '0;
            set_dropped <= 1'b0;
            fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (set_count < MAX_VERTICES) begin
                    set_x[set_count] = s_axis_tdata[31:0];
                    set_y[set_count] = s_axis_tdata[63:32];
                    set_z[set_count] = s_axis_tdata[95:64];
                    sum_x = sum_x + $signed(s_axis_tdata[31:0]);
                    sum_y = sum_y + $signed(s_axis_tdata[63:32]);
                    sum_z = sum_z + $signed(s_axis_tdata[95:64]);
                    set_count = set_count + 1;
                end else begin
                    set_dropped = 1'b1;
                end
                if (s_axis_tlast) begin
                    expected_spheres.push_back(predict_sphere());
                    set_count = 0;
                    sum_x = '0;
                    sum_y = '0;
                    sum_z = '0;
                    set_dropped = 1'b0;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.cx = m_axis_tdata[31:0];
                got.cy = m_axis_tdata[63:32];
                got.cz = m_axis_tdata[95:64];
                got.radius = m_axis_tdata[128:96];
                got.overflowed = m_axis_tdata[129];
                if (expected_spheres.size() == 0) begin
                    $error("unexpected result transaction");
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_spheres.pop_front();
                    if (got != want) fail_count <= fail_count + 1;
                    if (got.cx != want.cx)
                        $error("center_x expected %h got %h", want.cx, got.cx);
                    if (got.cy != want.cy)
                        $error("center_y expected %h got %h", want.cy, got.cy);
                    if (got.cz != want.cz)
                        $error("center_z expected %h got %h", want.cz, got.cz);
                    if (got.radius != want.radius)
                        $error("radius expected %h got %h", want.radius, got.radius);
                    if (got.overflowed != want.overflowed)
                        $error("overflowed expected %b got %b",
                               want.overflowed, got.overflowed);
                end
            end
        end
    end

endmodule

@@ tb/bounding_sphere_mean_distance_tb.sv @@
// ----------------------------------------------------------------------------
// bounding_sphere_mean_distance_tb
// Drives vertex sets into the block: directed sets with extreme coordinates,
// single-vertex sets and a set that overruns the vertex memory, then random
// sets of one to twelve vertices, with random gaps on both channels.
// ----------------------------------------------------------------------------
module bounding_sphere_mean_distance_tb;
    import bsmd_pkg::*;

    localparam int unsigned MAX_VERTICES = MaxVerticesDefault;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;   // vertex_x, vertex_y, vertex_z
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;   // center_x, center_y, center_z, radius, overflowed
    logic         m_axis_tlast;
    int           fail_count;
    int           pending_spheres;
    int           vertices_sent;
    int           rdy_wait;
    bit           stim_done;

    bounding_sphere_mean_distance #(.MAX_VERTICES(MAX_VERTICES)) uut (.*);

    bounding_sphere_mean_distance_checker #(.MAX_VERTICES(MAX_VERTICES)) checker_i (.*);

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic logic [31:0] pick_coord(input int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) << 12;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 1)) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        s_axis_tlast <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        vertices_sent++;
    endtask

    task automatic stop_input();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_set(input int size, input int mode);
        for (int i = 0; i < size; i++)
            send_vertex(pick_coord(mode), pick_coord(mode), pick_coord(mode),
                        i == size - 1);
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        vertices_sent = 0;
        stim_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_set(1, 0);
        send_set(1, 1);
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
        send_vertex(32'hffff_ffff, 32'h0, 32'h1, 1'b0);
        send_vertex(32'h0, 32'hffff_ffff, 32'h0, 1'b1);
        send_set(4, 3);
        send_set(5, 2);
        stop_input();
        while (pending_spheres != 0) @(posedge aclk);
        // overrun of the vertex memory, last marker on a dropped vertex
        send_set(MAX_VERTICES + 3, 3);
        while (vertices_sent < 1350) begin
            case ($urandom_range(0, 3))
                0: send_set(1, $urandom_range(0, 3));
                default: send_set($urandom_range(2, 12), $urandom_range(2, 3));
            endcase
        end
        stop_input();
        stim_done = 1'b1;
    end

    always @(posedge aclk) begin
        int draw;
        draw = $urandom_range(0, 16);
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rdy_wait <= draw;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (draw != 0) m_axis_tready <= 1'b0;
            rdy_wait <= draw;
        end else if (!m_axis_tready) begin
            if (rdy_wait == 0) m_axis_tready <= 1'b1;
            else rdy_wait <= rdy_wait - 1;
        end
    end

    initial begin
        wait (stim_done);
        while (pending_spheres != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bsmd_pkg.sv
hw/rtl/bsmd_divider.sv
hw/rtl/bsmd_sqrt.sv
hw/rtl/bounding_sphere_mean_distance.sv
tb/bounding_sphere_mean_distance_checker.sv
tb/bounding_sphere_mean_distance_tb.sv
